@@ hdl/adaptive_tick_mode_controller_core_assert.svh @@
// Assertion macros for the adaptive tick mode controller core.
// Expects clk_i and rst_ni in the scope of the module that uses them.
`ifndef ADAPTIVE_TICK_MODE_CONTROLLER_CORE_ASSERT_SVH
`define ADAPTIVE_TICK_MODE_CONTROLLER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define ATMC_ASSERT_IMPLY(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("atmc: implication check failed");

// Next-cycle implication, disabled during reset.
`define ATMC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("atmc: next-cycle check failed");

`endif

@@ hdl/atmc_pkg.sv @@
// Package for the adaptive tick mode controller: widths, constants, codes.
// No dependencies; imported by adaptive_tick_mode_controller_core.
`default_nettype none

package atmc_pkg;

  localparam int CMD_W     = 2;
  localparam int SEC_W     = 32;
  localparam int USEC_W    = 20;
  localparam int MS_W      = 42;
  localparam int US_W      = 52;
  localparam int AVG_W     = 32;
  localparam int PERIOD_W  = 23;
  localparam int MARK_W    = 16;
  localparam int COUNT_W   = 23;
  localparam int CFG_IDX_W = 2;
  localparam int BIAS_W    = 22;  // holds usec + 2000000 - usec
  localparam int KREM_W    = 10;  // remainder of a division by 1000
  localparam int STEP_W    = 5;

  localparam int MS_PER_SEC       = 1000;
  localparam int US_PER_SEC       = 1000000;
  localparam int USEC_BIAS        = 2000000;
  localparam int ELAPSED_BIAS_MS  = 2000;
  localparam int RATE_SCALE_SHIFT = 9;    // count * 512
  localparam int AVG_ROUND        = 64;
  localparam int AVG_SHIFT        = 7;    // divide by 128

  localparam logic [STEP_W-1:0]   STEP_LAST  = STEP_W'(SEC_W - 1);
  localparam logic [COUNT_W-1:0]  COUNT_MAX  = '1;
  localparam logic [COUNT_W-1:0]  COUNT_ONE  = COUNT_W'(1);

  localparam logic [PERIOD_W-1:0] TICK_PERIOD_RST = PERIOD_W'(10);
  localparam logic [MARK_W-1:0]   LOW_MARK_RST    = MARK_W'(10);
  localparam logic [MARK_W-1:0]   HIGH_MARK_RST   = MARK_W'(200);

  typedef enum logic [CMD_W-1:0] {
    CMD_ALARM   = 2'd0,
    CMD_QUERY   = 2'd1,
    CMD_RESOLVE = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ACT_NONE     = 2'd0,
    ACT_ONESHOT  = 2'd1,
    ACT_PERIODIC = 2'd2
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TICK_PERIOD = 2'd0,
    REG_LOW_MARK    = 2'd1,
    REG_HIGH_MARK   = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_EVAL,
    ST_DIV_TD,
    ST_RATE_LOAD,
    ST_DIV_RATE,
    ST_AVG,
    ST_FINISH
  } state_e;

endpackage

`default_nettype wire

@@ hdl/adaptive_tick_mode_controller_core.sv @@
// Adaptive tick mode controller: latched wall time, query-rate average and
// one-shot/periodic timer decision. Depends on atmc_pkg and the assert header.
//
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0 tick period, 1 low mark, 2 high mark); write only while idle.
// Input channel (in_valid_i / in_stall_o) takes one command with a sampled
// wall time; output channel (out_valid_o / out_stall_i) returns exactly one
// result per command.
// Path from acceptance to result: alarms, ignored codes and commands that find
// no pending alarm go straight to the result; a command that latches a new
// time first runs a bit-serial pass for the time scaling and the two
// divisions by 1000; a counted query that resolves a pending alarm with
// non-zero elapsed time then also runs two 32-step passes of the shared
// restoring divider, elapsed/period then count*512/quotient.
// One transaction is in work at a time; the next can be taken in the cycle
// after the result is loaded. A stalled result waits in the output register
// while one more transaction is taken; that one's result is held back until
// the register is free.
// Reset clears the latch, the average and the count, sets the pending flag
// and restores the register defaults (10, 10, 200).
`default_nettype none
`include "adaptive_tick_mode_controller_core_assert.svh"

module adaptive_tick_mode_controller_core
  import atmc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [PERIOD_W-1:0]  cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [CMD_W-1:0]     command_i,
  input  logic [SEC_W-1:0]     sample_sec_i,
  input  logic [USEC_W-1:0]    sample_usec_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [MS_W-1:0]      time_ms_o,
  output logic [US_W-1:0]      time_us_o,
  output logic [1:0]           timer_action_o,
  output logic [AVG_W-1:0]     rate_average_o
);

  // control and architectural state
  state_e               state_q, state_d;
  logic [STEP_W-1:0]    step_q;
  logic [CMD_W-1:0]     cmd_q;
  logic                 resolve_q;
  logic                 pending_q;
  logic                 periodic_q;
  logic [COUNT_W-1:0]   count_q;
  logic [AVG_W-1:0]     rate_avg_q;
  logic [SEC_W-1:0]     now_sec_q;
  logic [USEC_W-1:0]    now_usec_q;
  logic [MS_W-1:0]      time_ms_q;
  logic [US_W-1:0]      time_us_q;
  logic [PERIOD_W-1:0]  tick_q;
  logic [MARK_W-1:0]    low_q;
  logic [MARK_W-1:0]    high_q;
  logic                 out_valid_q;

  // serial datapath
  logic [SEC_W-1:0]     sec_sh_q;
  logic [SEC_W-1:0]     diff_sh_q;
  logic [USEC_W-1:0]    usec_sh_q;
  logic [BIAS_W-1:0]    bias_sh_q;
  logic [KREM_W-1:0]    urem_q;
  logic [KREM_W-1:0]    brem_q;
  logic [MS_W-1:0]      ms_acc_q;
  logic [US_W-1:0]      us_acc_q;
  logic [SEC_W-1:0]     dms_acc_q;
  logic [SEC_W-1:0]     rem_q;
  logic [SEC_W-1:0]     quo_q;
  logic [SEC_W-1:0]     dvs_q;

  // output register payload
  logic [MS_W-1:0]      out_ms_q;
  logic [US_W-1:0]      out_us_q;
  logic [1:0]           out_action_q;
  logic [AVG_W-1:0]     out_avg_q;

  logic                 in_fire;
  logic                 out_free;
  logic                 latch_now;
  logic                 resolve_now;
  logic [KREM_W:0]      u_trial;
  logic                 u_ge;
  logic [KREM_W-1:0]    u_rem_next;
  logic [KREM_W:0]      b_trial;
  logic                 b_ge;
  logic [KREM_W-1:0]    b_rem_next;
  logic [SEC_W:0]       d_trial;
  logic [SEC_W:0]       d_diff;
  logic                 d_ge;
  logic [SEC_W-1:0]     d_rem_next;
  logic [SEC_W-1:0]     td_d;
  logic [SEC_W-1:0]     period_eff;
  logic [SEC_W-1:0]     quo_eff;
  logic [AVG_W-1:0]     avg_sum;
  logic [AVG_W-1:0]     avg_next;
  logic [COUNT_W-1:0]   count_inc;
  action_e              action_d;
  logic                 periodic_next;

  assign in_fire     = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign resolve_now = (command_i == CMD_QUERY) && pending_q;
  assign latch_now   = (command_i inside {CMD_QUERY, CMD_RESOLVE}) && pending_q;

  // restoring divisions by 1000, one dividend bit per cycle
  assign u_trial    = {urem_q, usec_sh_q[USEC_W-1]};
  assign u_ge       = u_trial >= (KREM_W+1)'(MS_PER_SEC);
  assign u_rem_next = u_ge ? KREM_W'(u_trial - (KREM_W+1)'(MS_PER_SEC)) : u_trial[KREM_W-1:0];
  assign b_trial    = {brem_q, bias_sh_q[BIAS_W-1]};
  assign b_ge       = b_trial >= (KREM_W+1)'(MS_PER_SEC);
  assign b_rem_next = b_ge ? KREM_W'(b_trial - (KREM_W+1)'(MS_PER_SEC)) : b_trial[KREM_W-1:0];

  // shared variable divider step
  assign d_trial    = {rem_q, quo_q[SEC_W-1]};
  assign d_diff     = d_trial - {1'b0, dvs_q};
  assign d_ge       = d_trial >= {1'b0, dvs_q};
  assign d_rem_next = d_ge ? d_diff[SEC_W-1:0] : d_trial[SEC_W-1:0];

  // elapsed ms: undo the 2000 ms bias that kept the usec difference positive
  assign td_d       = dms_acc_q + SEC_W'(bias_sh_q) - SEC_W'(ELAPSED_BIAS_MS);
  assign period_eff = (tick_q == '0) ? SEC_W'(1) : SEC_W'(tick_q);
  assign quo_eff    = (quo_q == '0) ? SEC_W'(1) : quo_q;

  assign avg_sum  = quo_q + {rate_avg_q[AVG_W-7:0], 6'b0} + {rate_avg_q[AVG_W-6:0], 5'b0}
                    + AVG_W'(AVG_ROUND);
  assign avg_next = avg_sum >> AVG_SHIFT;

  assign count_inc = (count_q == COUNT_MAX) ? count_q : count_q + COUNT_ONE;

  // hysteresis between one-shot and periodic mode
  always_comb begin
    action_d      = ACT_NONE;
    periodic_next = periodic_q;
    if (periodic_q) begin
      if (rate_avg_q < AVG_W'(low_q)) begin
        action_d      = ACT_ONESHOT;
        periodic_next = 1'b0;
      end
    end else if (rate_avg_q > AVG_W'(high_q)) begin
      action_d      = ACT_PERIODIC;
      periodic_next = 1'b1;
    end else begin
      action_d = ACT_ONESHOT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_stall_o = (state_q != ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = latch_now ? ST_MUL : ST_FINISH;
        end
      end
      ST_MUL: begin
        if (step_q == '0) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        // zero elapsed time keeps the average
        state_d = (resolve_q && (td_d != '0)) ? ST_DIV_TD : ST_FINISH;
      end
      ST_DIV_TD: begin
        if (step_q == '0) begin
          state_d = ST_RATE_LOAD;
        end
      end
      ST_RATE_LOAD: state_d = ST_DIV_RATE;
      ST_DIV_RATE: begin
        if (step_q == '0) begin
          state_d = ST_AVG;
        end
      end
      ST_AVG: state_d = ST_FINISH;
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      cmd_q       <= '0;
      resolve_q   <= 1'b0;
      pending_q   <= 1'b1;
      periodic_q  <= 1'b0;
      count_q     <= '0;
      rate_avg_q  <= '0;
      now_sec_q   <= '0;
      now_usec_q  <= '0;
      time_ms_q   <= '0;
      time_us_q   <= '0;
      tick_q      <= TICK_PERIOD_RST;
      low_q       <= LOW_MARK_RST;
      high_q      <= HIGH_MARK_RST;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_TICK_PERIOD: tick_q <= cfg_data_i;
          REG_LOW_MARK:    low_q  <= cfg_data_i[MARK_W-1:0];
          REG_HIGH_MARK:   high_q <= cfg_data_i[MARK_W-1:0];
          default: ;
        endcase
      end

      // load a new result, else drop the one just taken
      if ((state_q == ST_FINISH) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            cmd_q     <= command_i;
            resolve_q <= resolve_now;
            step_q    <= STEP_LAST;
            if (latch_now) begin
              now_sec_q  <= sample_sec_i;
              now_usec_q <= sample_usec_i;
            end
          end
        end
        ST_MUL, ST_DIV_TD, ST_DIV_RATE: begin
          step_q <= step_q - STEP_W'(1);
        end
        ST_EVAL: begin
          time_ms_q <= ms_acc_q + MS_W'(usec_sh_q);
          time_us_q <= us_acc_q + US_W'(now_usec_q);
          step_q    <= STEP_LAST;
        end
        ST_RATE_LOAD: begin
          step_q <= STEP_LAST;
        end
        ST_AVG: begin
          rate_avg_q <= avg_next;
        end
        ST_FINISH: begin
          if (out_free) begin
            case (cmd_q)
              CMD_ALARM: pending_q <= 1'b1;
              CMD_QUERY: begin
                if (resolve_q) begin
                  // clear the count, then count this query
                  periodic_q <= periodic_next;
                  pending_q  <= 1'b0;
                  count_q    <= COUNT_ONE;
                end else begin
                  count_q <= count_inc;
                end
              end
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          sec_sh_q  <= sample_sec_i;
          diff_sh_q <= sample_sec_i - now_sec_q;
          usec_sh_q <= sample_usec_i;
          bias_sh_q <= BIAS_W'(sample_usec_i) + BIAS_W'(USEC_BIAS) - BIAS_W'(now_usec_q);
          urem_q    <= '0;
          brem_q    <= '0;
          ms_acc_q  <= '0;
          us_acc_q  <= '0;
          dms_acc_q <= '0;
        end
      end
      ST_MUL: begin
        // MSB-first shift-and-add by the constant scale factors
        sec_sh_q  <= {sec_sh_q[SEC_W-2:0], 1'b0};
        diff_sh_q <= {diff_sh_q[SEC_W-2:0], 1'b0};
        ms_acc_q  <= {ms_acc_q[MS_W-2:0], 1'b0}
                     + (sec_sh_q[SEC_W-1] ? MS_W'(MS_PER_SEC) : '0);
        us_acc_q  <= {us_acc_q[US_W-2:0], 1'b0}
                     + (sec_sh_q[SEC_W-1] ? US_W'(US_PER_SEC) : '0);
        dms_acc_q <= {dms_acc_q[SEC_W-2:0], 1'b0}
                     + (diff_sh_q[SEC_W-1] ? SEC_W'(MS_PER_SEC) : '0);
        // narrow dividends run only over their own last bits
        if (step_q < STEP_W'(USEC_W)) begin
          urem_q    <= u_rem_next;
          usec_sh_q <= {usec_sh_q[USEC_W-2:0], u_ge};
        end
        if (step_q < STEP_W'(BIAS_W)) begin
          brem_q    <= b_rem_next;
          bias_sh_q <= {bias_sh_q[BIAS_W-2:0], b_ge};
        end
      end
      ST_EVAL: begin
        rem_q <= '0;
        quo_q <= td_d;
        dvs_q <= period_eff;
      end
      ST_DIV_TD, ST_DIV_RATE: begin
        rem_q <= d_rem_next;
        quo_q <= {quo_q[SEC_W-2:0], d_ge};
      end
      ST_RATE_LOAD: begin
        rem_q <= '0;
        quo_q <= SEC_W'(count_q) << RATE_SCALE_SHIFT;
        dvs_q <= quo_eff;
      end
      ST_FINISH: begin
        if (out_free) begin
          out_ms_q     <= time_ms_q;
          out_us_q     <= time_us_q;
          out_action_q <= (cmd_q == CMD_QUERY && resolve_q) ? action_d : ACT_NONE;
          out_avg_q    <= rate_avg_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign time_ms_o      = out_ms_q;
  assign time_us_o      = out_us_q;
  assign timer_action_o = out_action_q;
  assign rate_average_o = out_avg_q;

  `ATMC_ASSERT_IMPLY(a_periodic_enter, $rose(periodic_q),
                     out_valid_o && (timer_action_o == ACT_PERIODIC))
  `ATMC_ASSERT_IMPLY(a_periodic_leave, $fell(periodic_q),
                     out_valid_o && (timer_action_o == ACT_ONESHOT))
  `ATMC_ASSERT_IMPLY(a_resolve_recount, $fell(pending_q), count_q == COUNT_ONE)
  `ATMC_ASSERT_NEXT(a_accept_busy, in_valid_i && !in_stall_o,
                    in_stall_o && $stable(rate_avg_q))

endmodule

`default_nettype wire
